// ===== hw/rtl/kcp_pkg.sv =====
// Shared types and constants for the Kalman covariance prediction block.
// Used by kcp_ctrl, kcp_datapath and kalman_covariance_predict; no dependencies.
package kcp_pkg;

	localparam int MaxDim      = 64;
	localparam int DimW        = $clog2(MaxDim);
	localparam int AddrW       = 2 * DimW;
	localparam int Depth       = MaxDim * MaxDim;
	localparam int DataW       = 32;
	localparam int CfgW        = 8;
	localparam int CntW        = DimW + 1;
	localparam int AccW        = 2 * DataW + DimW;
	localparam int DrainCycles = 7;
	localparam int DrainW      = $clog2(DrainCycles);

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_COMPUTE = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SEL_F     = 2'd0,
		SEL_PRIOR = 2'd1,
		SEL_G     = 2'd2,
		SEL_Q     = 2'd3
	} sel_t;

	// Product stages of one compute request, in order.
	typedef enum logic [1:0] {
		STG_FP  = 2'd0,
		STG_SFT = 2'd1,
		STG_GQ  = 2'd2,
		STG_SGT = 2'd3
	} stage_t;

	typedef enum logic [1:0] {
		SRC_ZERO     = 2'd0,
		SRC_READ     = 2'd1,
		SRC_MISMATCH = 2'd2
	} out_src_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN
	} state_t;

	localparam int CfgIdxW = 1;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_STATE_DIM = 1'b0,
		CFG_NOISE_DIM = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic            load;
		logic            issue;
		logic            first;
		logic            last;
		stage_t          stage;
		logic [DimW-1:0] i;
		logic [DimW-1:0] j;
		logic [DimW-1:0] k;
		logic            out_ld;
		out_src_t        out_src;
	} cmd_t;

endpackage

// ===== hw/rtl/kcp_ctrl.sv =====
// Controller of the Kalman covariance prediction block: handshake, configuration
// registers and the loop sequencer of the product stages. Depends on kcp_pkg.
module kcp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       cfg_we,
	input  logic [kcp_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [kcp_pkg::CfgW-1:0]   cfg_data,
	output kcp_pkg::cmd_t              cmd
);

	kcp_pkg::state_t                 state_q, state_d;
	kcp_pkg::stage_t                 stage_q, stage_d;
	logic [kcp_pkg::DimW-1:0]        i_q, i_d, j_q, j_d, k_q, k_d;
	logic [kcp_pkg::DrainW-1:0]      drain_q, drain_d;
	logic [kcp_pkg::CfgW-1:0]        n_q, p_q;
	logic                            out_valid_q, out_valid_d;
	logic [kcp_pkg::CntW-1:0]        rows, inner, cols;
	logic [kcp_pkg::CntW-1:0]        rows_m1, inner_m1, cols_m1;
	logic                            k_last, j_last, i_last;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kcp_pkg::ST_IDLE;
			stage_q     <= kcp_pkg::STG_FP;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
			n_q         <= kcp_pkg::CfgW'(4);
			p_q         <= kcp_pkg::CfgW'(4);
		end else begin
			state_q     <= state_d;
			stage_q     <= stage_d;
			i_q         <= i_d;
			j_q         <= j_d;
			k_q         <= k_d;
			drain_q     <= drain_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				unique case (kcp_pkg::cfg_idx_t'(cfg_index))
					kcp_pkg::CFG_STATE_DIM: n_q <= cfg_data;
					kcp_pkg::CFG_NOISE_DIM: p_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Loop bounds of the current stage; only used once n and p are known to fit.
	always_comb begin
		rows = n_q[kcp_pkg::CntW-1:0];
		case (stage_q)
			kcp_pkg::STG_FP, kcp_pkg::STG_SFT: begin
				inner = n_q[kcp_pkg::CntW-1:0];
				cols  = n_q[kcp_pkg::CntW-1:0];
			end
			kcp_pkg::STG_GQ: begin
				inner = p_q[kcp_pkg::CntW-1:0];
				cols  = p_q[kcp_pkg::CntW-1:0];
			end
			default: begin
				inner = p_q[kcp_pkg::CntW-1:0];
				cols  = n_q[kcp_pkg::CntW-1:0];
			end
		endcase
		rows_m1  = rows - kcp_pkg::CntW'(1);
		inner_m1 = inner - kcp_pkg::CntW'(1);
		cols_m1  = cols - kcp_pkg::CntW'(1);
		k_last   = {1'b0, k_q} == inner_m1;
		j_last   = {1'b0, j_q} == cols_m1;
		i_last   = {1'b0, i_q} == rows_m1;
	end

	always_comb begin
		state_d     = state_q;
		stage_d     = stage_q;
		i_d         = i_q;
		j_d         = j_q;
		k_d         = k_q;
		drain_d     = drain_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.stage   = stage_q;
		cmd.i       = i_q;
		cmd.j       = j_q;
		cmd.k       = k_q;
		cmd.out_src = kcp_pkg::SRC_ZERO;

		unique case (state_q)
			kcp_pkg::ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					unique case (kcp_pkg::op_t'(operation))
						kcp_pkg::OP_LOAD: begin
							cmd.load   = 1'b1;
							cmd.out_ld = 1'b1;
						end
						kcp_pkg::OP_COMPUTE: begin
							if (n_q > kcp_pkg::CfgW'(kcp_pkg::MaxDim) ||
							    p_q > kcp_pkg::CfgW'(kcp_pkg::MaxDim)) begin
								cmd.out_ld  = 1'b1;
								cmd.out_src = kcp_pkg::SRC_MISMATCH;
							end else begin
								stage_d = kcp_pkg::STG_FP;
								state_d = kcp_pkg::ST_SETUP;
							end
						end
						kcp_pkg::OP_READ: state_d = kcp_pkg::ST_READ;
						kcp_pkg::OP_NONE: cmd.out_ld = 1'b1;
					endcase
				end
			end
			kcp_pkg::ST_READ: begin
				cmd.out_ld  = 1'b1;
				cmd.out_src = kcp_pkg::SRC_READ;
				state_d     = kcp_pkg::ST_IDLE;
			end
			kcp_pkg::ST_SETUP: begin
				// A stage with an empty dimension leaves its target unchanged.
				if (rows == '0 || inner == '0 || cols == '0) begin
					if (stage_q == kcp_pkg::STG_SGT) begin
						cmd.out_ld = 1'b1;
						state_d    = kcp_pkg::ST_IDLE;
					end else begin
						stage_d = kcp_pkg::stage_t'(stage_q + 2'd1);
					end
				end else begin
					i_d     = '0;
					j_d     = '0;
					k_d     = '0;
					state_d = kcp_pkg::ST_RUN;
				end
			end
			kcp_pkg::ST_RUN: begin
				cmd.issue = 1'b1;
				cmd.first = k_q == '0;
				cmd.last  = k_last;
				if (k_last) begin
					k_d = '0;
					if (j_last) begin
						j_d = '0;
						if (i_last) begin
							drain_d = '0;
							state_d = kcp_pkg::ST_DRAIN;
						end else begin
							i_d = i_q + kcp_pkg::DimW'(1);
						end
					end else begin
						j_d = j_q + kcp_pkg::DimW'(1);
					end
				end else begin
					k_d = k_q + kcp_pkg::DimW'(1);
				end
			end
			kcp_pkg::ST_DRAIN: begin
				// Let the last writes of this stage land before the next one reads.
				drain_d = drain_q + kcp_pkg::DrainW'(1);
				if (drain_q == kcp_pkg::DrainW'(kcp_pkg::DrainCycles - 1)) begin
					if (stage_q == kcp_pkg::STG_SGT) begin
						cmd.out_ld = 1'b1;
						state_d    = kcp_pkg::ST_IDLE;
					end else begin
						stage_d = kcp_pkg::stage_t'(stage_q + 2'd1);
						state_d = kcp_pkg::ST_SETUP;
					end
				end
			end
			default: state_d = kcp_pkg::ST_IDLE;
		endcase

		out_valid_d = cmd.out_ld || (out_valid_q && !out_ready);
	end

endmodule

// ===== hw/rtl/kcp_datapath.sv =====
// Datapath of the Kalman covariance prediction block: six matrix stores, the
// multiply-accumulate pipeline, rounding, saturation and the result register.
// Depends on kcp_pkg.
module kcp_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kcp_pkg::cmd_t                     cmd,
	input  logic [1:0]                        matrix_sel,
	input  logic [kcp_pkg::DimW-1:0]          row_index,
	input  logic [kcp_pkg::DimW-1:0]          col_index,
	input  logic signed [kcp_pkg::DataW-1:0]  elem_value,
	output logic signed [kcp_pkg::DataW-1:0]  result_value,
	output logic                              status_code
);

	localparam int AW = kcp_pkg::AddrW;
	localparam int DW = kcp_pkg::DataW;
	localparam int CW = kcp_pkg::AccW;

	function automatic logic signed [DW-1:0] sat_word(input logic signed [CW-1:0] v);
		logic signed [DW-1:0] r;
		if (v[CW-1:DW-1] == '0 || v[CW-1:DW-1] == '1)
			r = v[DW-1:0];
		else if (v[CW-1])
			r = {1'b1, {(DW-1){1'b0}}};
		else
			r = {1'b0, {(DW-1){1'b1}}};
		return r;
	endfunction

	logic [DW-1:0] mem_f     [kcp_pkg::Depth];
	logic [DW-1:0] mem_prior [kcp_pkg::Depth];
	logic [DW-1:0] mem_g     [kcp_pkg::Depth];
	logic [DW-1:0] mem_q     [kcp_pkg::Depth];
	logic [DW-1:0] mem_s     [kcp_pkg::Depth];
	logic [DW-1:0] mem_pred  [kcp_pkg::Depth];

	logic [AW-1:0] a_addr, b_addr, f_addr, g_addr, pred_addr, ld_addr;
	logic [DW-1:0] f_rd_q, prior_rd_q, g_rd_q, q_rd_q, s_rd_q, pred_rd_q;

	logic                 v_s1, first_s1, last_s1;
	kcp_pkg::stage_t      stage_s1, stage_s2, stage_s3, stage_s4;
	logic [AW-1:0]        dst_s1, dst_s2, dst_s3, dst_s4;
	logic signed [DW-1:0] a_s1, b_s1;
	logic                 v_s2, first_s2, last_s2;
	logic signed [2*DW-1:0] prod_s2;
	logic [DW-1:0]        pred_s2, pred_s3, pred_s4;
	logic signed [CW-1:0] acc_s3, rsum, rsh, accum_sum;
	logic                 v_s3, v_s4;
	logic signed [DW-1:0] rnd_s4, wval;

	assign a_addr  = {cmd.i, cmd.k};
	assign b_addr  = (cmd.stage == kcp_pkg::STG_FP || cmd.stage == kcp_pkg::STG_GQ) ?
	                 {cmd.k, cmd.j} : {cmd.j, cmd.k};
	assign f_addr  = (cmd.stage == kcp_pkg::STG_FP) ? a_addr : b_addr;
	assign g_addr  = (cmd.stage == kcp_pkg::STG_GQ) ? a_addr : b_addr;
	// Outside a compute the result store is addressed by the request for reads.
	assign pred_addr = cmd.issue ? {cmd.i, cmd.j} : {row_index, col_index};
	assign ld_addr   = {row_index, col_index};

	always_ff @(posedge clk) begin
		f_rd_q     <= mem_f[f_addr];
		prior_rd_q <= mem_prior[b_addr];
		g_rd_q     <= mem_g[g_addr];
		q_rd_q     <= mem_q[b_addr];
		s_rd_q     <= mem_s[a_addr];
		pred_rd_q  <= mem_pred[pred_addr];
		if (cmd.load) begin
			case (kcp_pkg::sel_t'(matrix_sel))
				kcp_pkg::SEL_F:     mem_f[ld_addr]     <= elem_value;
				kcp_pkg::SEL_PRIOR: mem_prior[ld_addr] <= elem_value;
				kcp_pkg::SEL_G:     mem_g[ld_addr]     <= elem_value;
				default:            mem_q[ld_addr]     <= elem_value;
			endcase
		end
		if (v_s4) begin
			if (stage_s4 == kcp_pkg::STG_FP || stage_s4 == kcp_pkg::STG_GQ)
				mem_s[dst_s4] <= wval;
			else
				mem_pred[dst_s4] <= wval;
		end
	end

	always_comb begin
		case (stage_s1)
			kcp_pkg::STG_FP: begin
				a_s1 = f_rd_q;
				b_s1 = prior_rd_q;
			end
			kcp_pkg::STG_SFT: begin
				a_s1 = s_rd_q;
				b_s1 = f_rd_q;
			end
			kcp_pkg::STG_GQ: begin
				a_s1 = g_rd_q;
				b_s1 = q_rd_q;
			end
			default: begin
				a_s1 = s_rd_q;
				b_s1 = g_rd_q;
			end
		endcase
	end

	// Round half up to Q16.16 by adding half an LSB and flooring.
	assign rsum      = acc_s3 + CW'(32768);
	assign rsh       = rsum >>> 16;
	assign accum_sum = CW'(rnd_s4) + CW'($signed(pred_s4));
	assign wval      = (stage_s4 == kcp_pkg::STG_SGT) ? sat_word(accum_sum) : rnd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		stage_s1 <= cmd.stage;
		dst_s1   <= {cmd.i, cmd.j};

		prod_s2  <= (2*DW)'(a_s1) * (2*DW)'(b_s1);
		pred_s2  <= pred_rd_q;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		stage_s2 <= stage_s1;
		dst_s2   <= dst_s1;

		if (v_s2)
			acc_s3 <= first_s2 ? CW'(prod_s2) : acc_s3 + CW'(prod_s2);
		pred_s3  <= pred_s2;
		stage_s3 <= stage_s2;
		dst_s3   <= dst_s2;

		rnd_s4   <= sat_word(rsh);
		pred_s4  <= pred_s3;
		stage_s4 <= stage_s3;
		dst_s4   <= dst_s3;

		if (cmd.out_ld) begin
			case (cmd.out_src)
				kcp_pkg::SRC_READ: begin
					result_value <= pred_rd_q;
					status_code  <= 1'b0;
				end
				kcp_pkg::SRC_MISMATCH: begin
					result_value <= '0;
					status_code  <= 1'b1;
				end
				default: begin
					result_value <= '0;
					status_code  <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/kalman_covariance_predict.sv =====
// Top level of the Kalman covariance prediction block P = F*P'*F^T + G*Q*G^T.
// Instantiates kcp_ctrl and kcp_datapath; depends on kcp_pkg.
//
//  channel  signals                                     direction
//  in       in_valid/in_ready, operation..elem_value    request in
//  out      out_valid/out_ready, result_value, status   result out
//  cfg      cfg_we, cfg_index, cfg_data                 register write
//
// Load, unused and oversized compute requests are answered from the idle state,
// a read after a pass through the read state. A compute runs four product stages
// on one multiply-accumulate pipeline, one product per cycle, 2n^3 + n*p^2 + n^2*p
// products; each stage is set up and, if it ran, drained. Reset clears control
// state only; the matrix stores are undefined until loaded. A new request is
// taken once the block is idle and the result register is empty or being emptied.
module kalman_covariance_predict (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        operation,
	input  logic [1:0]                        matrix_sel,
	input  logic [5:0]                        row_index,
	input  logic [5:0]                        col_index,
	input  logic signed [31:0]                elem_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                result_value,
	output logic                              status_code,
	input  logic                              cfg_we,
	input  logic [kcp_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [kcp_pkg::CfgW-1:0]          cfg_data
);

	kcp_pkg::cmd_t cmd;

	kcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd)
	);

	kcp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.matrix_sel   (matrix_sel),
		.row_index    (row_index),
		.col_index    (col_index),
		.elem_value   (elem_value),
		.result_value (result_value),
		.status_code  (status_code)
	);

`ifndef SYNTH
	// A load answers in the next cycle with an all-zero result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == kcp_pkg::OP_LOAD) |=>
		(out_valid && result_value == '0 && !status_code))
		else $error("load request did not give a zero result");

	// A read passes through the read state, where the result store is read, before it answers.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == kcp_pkg::OP_READ) |=> !out_valid)
		else $error("read result appeared before the store was read");

	// Loads and unused requests answer at once and never report a size mismatch.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation != kcp_pkg::OP_COMPUTE &&
		 operation != kcp_pkg::OP_READ) |=> !status_code)
		else $error("mismatch status on a request that is not a compute");
`endif

endmodule
